FILE: sv/vtcf_pkg.sv
// ----------------------------------------------------------------------------
// vtcf_pkg
// Shared types and constants of the vertex transform, clip and fog block.
// ----------------------------------------------------------------------------
`default_nettype none

package vtcf_pkg;

	localparam int MATRIX_FRAC_BITS_DEF = 16;

	localparam int COORD_W  = 16;
	localparam int ENTRY_W  = 32;
	localparam int PROD_W   = COORD_W + ENTRY_W;
	localparam int COMP_W   = PROD_W + 1;
	localparam int MAG_W    = COMP_W - 1;
	localparam int QFRAC_W  = 16;
	localparam int QUO_W    = 47;
	localparam int QNUM_W   = MAG_W + QFRAC_W;
	localparam int SCALE_W  = 16;
	localparam int WIDE_W   = COMP_W + 5;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 128;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SCALE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SCALE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TRANS_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TRANS_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOG_SCALE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FOG_BIAS     = 3'd5;

	localparam logic [5:0] CLIP_X_LOW  = 6'h10;
	localparam logic [5:0] CLIP_X_HIGH = 6'h01;
	localparam logic [5:0] CLIP_Y_LOW  = 6'h20;
	localparam logic [5:0] CLIP_Y_HIGH = 6'h02;
	localparam logic [5:0] CLIP_NEAR   = 6'h04;

	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
		logic signed [COMP_W-1:0] w;
		logic                     last;
	} vert_t;

endpackage

`default_nettype wire

FILE: sv/vtcf_front.sv
// ----------------------------------------------------------------------------
// vtcf_front
// Input side: matrix loads and the two-stage matrix multiply of a vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcf_front import vtcf_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata, // coord_x, coord_y, coord_z, entry_index, entry_value
	input  wire                    s_axis_tuser, // kind
	input  wire                    s_axis_tlast,
	input  wire                    q_full,
	output logic                   q_push,
	output vert_t                  q_data
);

	logic signed [ENTRY_W-1:0] matrix_q [0:15];
	logic signed [PROD_W-1:0]  prod_c [0:11];
	logic signed [PROD_W-1:0]  prod_s1 [0:11];
	logic signed [ENTRY_W-1:0] row3_s1 [0:3];
	logic                      last_s1, last_s2;
	logic                      v_s1, v_s2;
	logic signed [COMP_W-1:0]  sum_c [0:3];
	logic signed [COMP_W-1:0]  sum_s2 [0:3];
	logic signed [COORD_W-1:0] coord [0:2];
	logic                      en_f, accept;

	assign coord[0] = s_axis_tdata[15:0];
	assign coord[1] = s_axis_tdata[31:16];
	assign coord[2] = s_axis_tdata[47:32];

	assign en_f          = !v_s2 || !q_full;
	assign s_axis_tready = en_f;
	assign accept        = s_axis_tvalid && en_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
		end else if (accept && s_axis_tuser == KIND_LOAD) begin
			matrix_q[s_axis_tdata[51:48]] <= s_axis_tdata[83:52];
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod_c[r*4+c] = coord[r] * matrix_q[r*4+c];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum_c[c] = COMP_W'(prod_s1[c]) + COMP_W'(prod_s1[4+c]) + COMP_W'(prod_s1[8+c])
				+ COMP_W'(row3_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en_f) begin
			v_s1 <= accept && s_axis_tuser == KIND_VERTEX;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			prod_s1 <= prod_c;
			for (int c = 0; c < 4; c++) row3_s1[c] <= matrix_q[12+c];
			last_s1 <= s_axis_tlast;
			sum_s2  <= sum_c;
			last_s2 <= last_s1;
		end
	end

	assign q_push      = v_s2 && !q_full;
	assign q_data.x    = sum_s2[0];
	assign q_data.y    = sum_s2[1];
	assign q_data.z    = sum_s2[2];
	assign q_data.w    = sum_s2[3];
	assign q_data.last = last_s2;

endmodule

`default_nettype wire

FILE: sv/vtcf_fifo.sv
// ----------------------------------------------------------------------------
// vtcf_fifo
// Short queue of transformed vertices between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcf_fifo import vtcf_pkg::*; (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push,
	input  vert_t  din,
	output logic   full,
	input  wire    pop,
	output vert_t  dout,
	output logic   empty
);

	vert_t                 mem [0:FIFO_DEPTH-1];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_PTR_W:0]   cnt_q;

	assign full  = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: sv/vtcf_div_pipe.sv
// ----------------------------------------------------------------------------
// vtcf_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcf_div_pipe import vtcf_pkg::*; #(
	parameter int NW = 64,
	parameter int DW = 48,
	parameter int QW = 47
) (
	input  wire           clk,
	input  wire           en,
	input  wire  [NW-1:0] num,
	input  wire  [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int RW0 = NW - QW;

	logic [DW-1:0] rem_q [1:QW-1];
	logic [DW-1:0] den_q [1:QW-1];
	logic [QW-1:0] num_q [1:QW-1];
	logic [QW-1:0] quo_q [1:QW];

	logic [DW-1:0] c_rem [0:QW-1];
	logic [DW-1:0] c_den [0:QW-1];
	logic [QW-1:0] c_num [0:QW-1];
	logic [QW-1:0] c_quo [0:QW-1];
	logic [DW-1:0] n_rem [0:QW-1];
	logic [QW-1:0] n_quo [0:QW-1];
	logic [DW:0]   sh    [0:QW-1];

	always_comb begin
		c_rem[0] = DW'(num[NW-1:NW-RW0]);
		c_den[0] = den;
		c_num[0] = num[QW-1:0];
		c_quo[0] = '0;
		for (int i = 1; i < QW; i++) begin
			c_rem[i] = rem_q[i];
			c_den[i] = den_q[i];
			c_num[i] = num_q[i];
			c_quo[i] = quo_q[i];
		end
		for (int i = 0; i < QW; i++) begin
			sh[i] = {c_rem[i], c_num[i][QW-1-i]};
			if (sh[i] >= {1'b0, c_den[i]}) begin
				n_rem[i] = DW'(sh[i] - {1'b0, c_den[i]});
				n_quo[i] = {c_quo[i][QW-2:0], 1'b1};
			end else begin
				n_rem[i] = DW'(sh[i]);
				n_quo[i] = {c_quo[i][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QW - 1; i++) begin
				rem_q[i+1] <= n_rem[i];
				den_q[i+1] <= c_den[i];
				num_q[i+1] <= c_num[i];
			end
			for (int i = 0; i < QW; i++) begin
				quo_q[i+1] <= n_quo[i];
			end
		end
	end

	assign quo = quo_q[QW];

endmodule

`default_nettype wire

FILE: sv/vtcf_back.sv
// ----------------------------------------------------------------------------
// vtcf_back
// Output side: perspective divides, viewport map, fog, reciprocal, clip codes.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcf_back import vtcf_pkg::*; #(
	parameter int MATRIX_FRAC_BITS = MATRIX_FRAC_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data,
	input  vert_t                  q_data,
	input  wire                    q_empty,
	output logic                   q_pop,
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata, // screen_x, screen_y, recip_w, clip_x_int,
	                                             // clip_y_int, clip_w_int, fog_level, clip_code
	output logic                   m_axis_tlast
);

	localparam int NST  = 1 + QUO_W + 3;
	localparam int QST  = 1 + QUO_W;
	localparam int RST  = 2 + 31;
	localparam logic signed [WIDE_W-1:0] ONE    = WIDE_W'(1) <<< MATRIX_FRAC_BITS;
	localparam logic signed [WIDE_W-1:0] ONE_M1 = ONE - WIDE_W'(1);
	localparam logic [QUO_W-1:0] QMAX = '1;

	typedef struct packed {
		logic                last;
		logic [5:0]          clip;
		logic [15:0]         ix;
		logic [15:0]         iy;
		logic [15:0]         iw;
		logic                w_neg;
		logic [2:0]          sgn;
		logic [2:0]          ovf;
		logic [2:0]          zero;
	} side_t;

	typedef struct packed {
		logic zero;
		logic neg;
	} rflag_t;

	logic signed [SCALE_W-1:0] scale_x_q, scale_y_q, trans_x_q, trans_y_q, fog_scale_q, fog_bias_q;
	logic                      vld_q [1:NST];
	logic                      en_b;

	side_t                     side_q [1:NST-1];
	side_t                     side_c;
	logic [MAG_W-1:0]          an_c [0:2];
	logic [MAG_W-1:0]          an_s1 [0:2];
	logic [MAG_W-1:0]          ad_c, ad_s1;
	logic signed [WIDE_W-1:0]  w31_full;
	logic [31:0]               w31_c, w31_s1;
	logic [QUO_W-1:0]          quo [0:2];
	logic signed [MAG_W-1:0]   qs_c [0:2];
	logic signed [MAG_W-1:0]   qs_s49 [0:2];
	logic signed [63:0]        prod_s50 [0:2];
	logic [OUT_TDATA_W-1:0]    out_c;

	logic [31:0]               u_c, u_s2;
	rflag_t                    rf_c;
	rflag_t                    rf_q [2:RST];
	logic [30:0]               rq;
	logic [31:0]               recip_c;
	logic [31:0]               rec_q [RST+1:NST-1];

	function automatic logic [31:0] keep_top(input logic [31:0] v, input logic [31:0] pat);
		int b;
		b = -1;
		for (int k = 31; k > 0; k--) begin
			if (v[k] && b < 0) b = k;
		end
		if (b > 0) return v & (pat >> (31 - b));
		return v;
	endfunction

	function automatic logic signed [WIDE_W-1:0] trunc_frac(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] a;
		a = v + (v < 0 ? ONE_M1 : WIDE_W'(0));
		return a >>> MATRIX_FRAC_BITS;
	endfunction

	function automatic logic [15:0] sat16(input logic signed [WIDE_W-1:0] v);
		if (v > WIDE_W'(32767)) return 16'h7FFF;
		if (v < -WIDE_W'(32768)) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic logic [15:0] map16(input logic signed [63:0] p,
			input logic signed [SCALE_W-1:0] tr);
		logic signed [64:0] t;
		logic signed [64:0] d;
		t = 65'(p) + (65'(tr) <<< 16);
		t = t + (t < 0 ? 65'sd65535 : 65'sd0);
		d = t >>> 16;
		if (d > 65'sd32767) return 16'h7FFF;
		if (d < -65'sd32768) return 16'h8000;
		return d[15:0];
	endfunction

	function automatic logic [7:0] fog8(input logic signed [63:0] p,
			input logic signed [SCALE_W-1:0] bias, input logic wneg);
		logic signed [64:0] t;
		logic signed [64:0] d;
		t = 65'(p) + (65'(bias) <<< 16);
		d = t >>> 16;
		if (wneg || t < 0) return 8'd0;
		if (d > 65'sd255) return 8'd255;
		return d[7:0];
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q   <= '0;
			scale_y_q   <= '0;
			trans_x_q   <= '0;
			trans_y_q   <= '0;
			fog_scale_q <= '0;
			fog_bias_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VIEW_SCALE_X: scale_x_q   <= cfg_data;
				CFG_VIEW_SCALE_Y: scale_y_q   <= cfg_data;
				CFG_VIEW_TRANS_X: trans_x_q   <= cfg_data;
				CFG_VIEW_TRANS_Y: trans_y_q   <= cfg_data;
				CFG_FOG_SCALE:    fog_scale_q <= cfg_data;
				CFG_FOG_BIAS:     fog_bias_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en_b  = !vld_q[NST] || m_axis_tready;
	assign q_pop = en_b && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) vld_q[i] <= 1'b0;
		end else if (en_b) begin
			vld_q[1] <= q_pop;
			for (int i = 2; i <= NST; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// stage 1: magnitudes, flags, integer parts, clip codes
	always_comb begin
		an_c[0] = MAG_W'(q_data.x < 0 ? -q_data.x : q_data.x);
		an_c[1] = MAG_W'(q_data.y < 0 ? -q_data.y : q_data.y);
		an_c[2] = MAG_W'(q_data.z < 0 ? -q_data.z : q_data.z);
		ad_c    = MAG_W'(q_data.w < 0 ? -q_data.w : q_data.w);
		side_c.last  = q_data.last;
		side_c.w_neg = q_data.w < 0;
		side_c.sgn   = {q_data.z[COMP_W-1], q_data.y[COMP_W-1], q_data.x[COMP_W-1]}
			^ {3{q_data.w[COMP_W-1]}};
		for (int k = 0; k < 3; k++) begin
			side_c.ovf[k]  = {31'b0, an_c[k]} >= {ad_c, 31'b0};
			side_c.zero[k] = an_c[k] == '0;
		end
		side_c.ix = sat16(trunc_frac(WIDE_W'(q_data.x)));
		side_c.iy = sat16(trunc_frac(WIDE_W'(q_data.y)));
		side_c.iw = sat16(trunc_frac(WIDE_W'(q_data.w)));
		side_c.clip = '0;
		if ((COMP_W+1)'(q_data.x) < -(COMP_W+1)'(q_data.w)) side_c.clip = side_c.clip | CLIP_X_LOW;
		if (q_data.x > q_data.w) side_c.clip = side_c.clip | CLIP_X_HIGH;
		if ((COMP_W+1)'(q_data.y) < -(COMP_W+1)'(q_data.w)) side_c.clip = side_c.clip | CLIP_Y_LOW;
		if (q_data.y > q_data.w) side_c.clip = side_c.clip | CLIP_Y_HIGH;
		if (WIDE_W'(q_data.w) * WIDE_W'(10) < ONE) side_c.clip = side_c.clip | CLIP_NEAR;
		w31_full = trunc_frac(WIDE_W'(q_data.w) * WIDE_W'(31));
		if (w31_full > WIDE_W'(32'sh7FFFFFFF)) w31_c = 32'h7FFFFFFF;
		else if (w31_full < -WIDE_W'(33'sh80000000)) w31_c = 32'h80000000;
		else w31_c = w31_full[31:0];
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			an_s1     <= an_c;
			ad_s1     <= ad_c;
			w31_s1    <= w31_c;
			side_q[1] <= side_c;
			for (int i = 2; i < NST; i++) side_q[i] <= side_q[i-1];
		end
	end

	generate
		for (genvar g = 0; g < 3; g++) begin : g_quot
			vtcf_div_pipe #(.NW(QNUM_W), .DW(MAG_W), .QW(QUO_W)) u_div (
				.clk (clk),
				.en  (en_b),
				.num ({an_s1[g], QFRAC_W'(0)}),
				.den (ad_s1),
				.quo (quo[g])
			);
		end
	endgenerate

	// reciprocal word
	always_comb begin
		rf_c.zero = w31_s1 == '0;
		rf_c.neg  = w31_s1[31];
		u_c = w31_s1;
		if (rf_c.neg) u_c = (w31_s1 >= 32'hFFFF8000) ? (32'd0 - w31_s1) : ~w31_s1;
		u_c = keep_top(u_c, 32'hFFC00000);
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			u_s2     <= u_c;
			rf_q[2]  <= rf_c;
			for (int i = 3; i <= RST; i++) rf_q[i] <= rf_q[i-1];
		end
	end

	vtcf_div_pipe #(.NW(32), .DW(32), .QW(31)) u_rcp (
		.clk (clk),
		.en  (en_b),
		.num (32'h7FFFFFFF),
		.den (u_s2),
		.quo (rq)
	);

	always_comb begin
		recip_c = keep_top({1'b0, rq}, 32'hFFFF8000);
		if (rf_q[RST].neg) recip_c = ~recip_c;
		if (rf_q[RST].zero) recip_c = 32'h7FFFFFFF;
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			rec_q[RST+1] <= recip_c;
			for (int i = RST + 2; i < NST; i++) rec_q[i] <= rec_q[i-1];
		end
	end

	// signed quotients, scale products
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (side_q[QST].zero[k]) qs_c[k] = '0;
			else if (side_q[QST].ovf[k])
				qs_c[k] = side_q[QST].sgn[k] ? -MAG_W'(QMAX) : MAG_W'(QMAX);
			else qs_c[k] = side_q[QST].sgn[k] ? -MAG_W'(quo[k]) : MAG_W'(quo[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			qs_s49 <= qs_c;
			prod_s50[0] <= qs_s49[0] * scale_x_q;
			prod_s50[1] <= qs_s49[1] * scale_y_q;
			prod_s50[2] <= qs_s49[2] * fog_scale_q;
		end
	end

	always_comb begin
		out_c = '0;
		out_c[15:0]    = map16(prod_s50[0], trans_x_q);
		out_c[31:16]   = map16(prod_s50[1], trans_y_q);
		out_c[63:32]   = rec_q[NST-1];
		out_c[79:64]   = side_q[NST-1].ix;
		out_c[95:80]   = side_q[NST-1].iy;
		out_c[111:96]  = side_q[NST-1].iw;
		out_c[119:112] = fog8(prod_s50[2], fog_bias_q, side_q[NST-1].w_neg);
		out_c[125:120] = side_q[NST-1].clip;
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			m_axis_tdata <= out_c;
			m_axis_tlast <= side_q[NST-1].last;
		end
	end

	assign m_axis_tvalid = vld_q[NST];

endmodule

`default_nettype wire

FILE: sv/vertex_transform_clip_fog.sv
// ----------------------------------------------------------------------------
// vertex_transform_clip_fog
// Homogeneous vertex transform with viewport map, fog, reciprocal and clip.
// ----------------------------------------------------------------------------
// s_axis carries items: tuser low is a vertex, high a matrix entry load.
// Loads update the 4x4 matrix at once and give no output; vertices after a
// load see the new entry. Each vertex gives one m_axis transfer, tlast
// copied from the input.
// cfg writes viewport and fog registers at once; write them only while idle.
// One vertex is taken every cycle until a full queue stalls the front end; the
// 47-stage quotient dividers set the depth. A four-entry queue parts the
// multiply front end from the divide back end. When m_axis stalls, the back
// end holds and the front end keeps taking vertices until the queue fills.
// Reset clears the matrix, the registers and all valid bits; there is no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_clip_fog import vtcf_pkg::*; #(
	parameter int MATRIX_FRAC_BITS = MATRIX_FRAC_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata, // coord_x, coord_y, coord_z, entry_index, entry_value
	input  wire                    s_axis_tuser, // kind
	input  wire                    s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata, // screen_x, screen_y, recip_w, clip_x_int,
	                                             // clip_y_int, clip_w_int, fog_level, clip_code
	output logic                   m_axis_tlast,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data
);

	vert_t q_in, q_out;
	logic  q_push, q_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	vtcf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_in)
	);

	vtcf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	vtcf_back #(.MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_data        (q_out),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb_vertex_transform_clip_fog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_clip_fog
// Self-checking bench for the vertex transform, clip and fog block.
// Matrix loads and vertices stream in with random gaps while the output side
// stalls at random; every vertex result is predicted from a local copy of the
// matrix and viewport/fog registers and checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vertex_transform_clip_fog;
	import vtcf_pkg::*;

	localparam longint QMAX      = 64'h7FFF_FFFF_FFFF;
	localparam longint ONE       = longint'(1) << MATRIX_FRAC_BITS_DEF;
	localparam int     LATENCY   = 60;
	localparam int     MAX_CYCLE = 300000;

	typedef struct {
		logic [15:0] screen_x;
		logic [15:0] screen_y;
		logic [31:0] recip_w;
		logic [15:0] clip_x_int;
		logic [15:0] clip_y_int;
		logic [15:0] clip_w_int;
		logic [7:0]  fog_level;
		logic [5:0]  clip_code;
		logic        batch_end;
	} vertex_result_t;

	class transform_checker;
		longint         matrix[16];
		longint         regs[6];
		vertex_result_t expected_results[$];
		int             errors, n_vertices, n_loads, n_results;

		function new();
			foreach (matrix[i]) matrix[i] = 0;
			foreach (regs[i]) regs[i] = 0;
			errors = 0; n_vertices = 0; n_loads = 0; n_results = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			regs[idx] = longint'($signed(val));
		endfunction

		function longint sat(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint quotient_q16(longint num, longint den);
			longint unsigned an, ad, ip, r, f, m;
			if (den == 0)
				return num > 0 ? QMAX : (num < 0 ? -QMAX : 0);
			an = num < 0 ? longint'(-num) : num;
			ad = den < 0 ? longint'(-den) : den;
			ip = an / ad;
			r  = an % ad;
			f  = 0;
			if (ip >= (64'd1 << 31)) begin
				m = QMAX;
			end else begin
				for (int i = 0; i < 16; i++) begin
					r = r << 1;
					f = f << 1;
					if (r >= ad) begin
						r = r - ad;
						f = f | 1;
					end
				end
				m = (ip << 16) | f;
			end
			return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
		endfunction

		function int top_bit(bit [31:0] v);
			for (int b = 31; b > 0; b--)
				if (v[b]) return b;
			return -1;
		endfunction

		function bit [31:0] emulated_rcp(bit [31:0] u);
			bit        neg;
			bit [31:0] q;
			int        b;
			if (u == 0) return 32'h7FFF_FFFF;
			neg = u[31];
			if (neg) u = (u >= 32'hFFFF_8000) ? (32'd0 - u) : ~u;
			b = top_bit(u);
			if (b > 0) u = u & (32'hFFC0_0000 >> (31 - b));
			q = 32'h7FFF_FFFF / u;
			b = top_bit(q);
			if (b > 0) q = q & (32'hFFFF_8000 >> (31 - b));
			return neg ? ~q : q;
		endfunction

		function longint viewport_map(longint q, longint scale, longint trans);
			return sat((q * scale + trans * 65536) / 65536, -32768, 32767);
		endfunction

		function void note_item(logic kind, logic [IN_TDATA_W-1:0] data, logic last);
			longint         c[3], r[4], w31, fog;
			vertex_result_t e;
			if (kind == KIND_LOAD) begin
				matrix[data[51:48]] = longint'($signed(data[83:52]));
				n_loads++;
				return;
			end
			c[0] = longint'($signed(data[15:0]));
			c[1] = longint'($signed(data[31:16]));
			c[2] = longint'($signed(data[47:32]));
			for (int k = 0; k < 4; k++)
				r[k] = c[0] * matrix[k] + c[1] * matrix[4 + k]
				     + c[2] * matrix[8 + k] + matrix[12 + k];
			w31 = sat((r[3] * 31) / ONE, -64'sd2147483648, 64'sd2147483647);
			if (r[3] < 0) begin
				fog = 0;
			end else begin
				fog = (quotient_q16(r[2], r[3]) * regs[CFG_FOG_SCALE]
				       + regs[CFG_FOG_BIAS] * 65536) / 65536;
				fog = sat(fog, 0, 255);
			end
			e.clip_code = 6'h00;
			if (r[0] < -r[3]) e.clip_code |= CLIP_X_LOW;
			if (r[0] > r[3]) e.clip_code |= CLIP_X_HIGH;
			if (r[1] < -r[3]) e.clip_code |= CLIP_Y_LOW;
			if (r[1] > r[3]) e.clip_code |= CLIP_Y_HIGH;
			if (r[3] * 10 < ONE) e.clip_code |= CLIP_NEAR;
			e.screen_x   = 16'(viewport_map(quotient_q16(r[0], r[3]),
				regs[CFG_VIEW_SCALE_X], regs[CFG_VIEW_TRANS_X]));
			e.screen_y   = 16'(viewport_map(quotient_q16(r[1], r[3]),
				regs[CFG_VIEW_SCALE_Y], regs[CFG_VIEW_TRANS_Y]));
			e.recip_w    = emulated_rcp(32'(w31));
			e.clip_x_int = 16'(sat(r[0] / ONE, -32768, 32767));
			e.clip_y_int = 16'(sat(r[1] / ONE, -32768, 32767));
			e.clip_w_int = 16'(sat(r[3] / ONE, -32768, 32767));
			e.fog_level  = 8'(fog);
			e.batch_end  = last;
			expected_results.push_back(e);
			n_vertices++;
		endfunction

		function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
			vertex_result_t e;
			n_results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer, tdata %h", data);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			compare("screen_x", e.screen_x, data[15:0]);
			compare("screen_y", e.screen_y, data[31:16]);
			compare("recip_w", e.recip_w, data[63:32]);
			compare("clip_x_int", e.clip_x_int, data[79:64]);
			compare("clip_y_int", e.clip_y_int, data[95:80]);
			compare("clip_w_int", e.clip_w_int, data[111:96]);
			compare("fog_level", e.fog_level, data[119:112]);
			compare("clip_code", e.clip_code, data[125:120]);
			compare("batch_end", e.batch_end, last);
		endfunction
	endclass

	logic                   clk, arst_n;
	logic                   s_axis_tvalid, s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser, s_axis_tlast;
	logic                   m_axis_tvalid, m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	transform_checker checker_h;
	bit               no_gaps, no_stalls, hold_off;
	int               cycle_count;

	vertex_transform_clip_fog DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLE) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready = 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			if (!no_stalls) begin
				int stall;
				stall = $urandom_range(0, 6);
				if (stall > 0) begin
					m_axis_tready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			m_axis_tready = 1'b1;
			forever begin
				@(posedge clk);
				if (m_axis_tvalid) break;
			end
			checker_h.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	task automatic send_item(logic kind, logic [15:0] x, logic [15:0] y, logic [15:0] z,
		logic [3:0] idx, logic [31:0] val, logic last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tlast  = last;
		s_axis_tdata  = {4'h0, val, idx, z, y, x};
		forever begin
			@(posedge clk);
			if (s_axis_tready) break;
		end
		checker_h.note_item(kind, s_axis_tdata, last);
		@(negedge clk);
	endtask

	task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
		send_item(KIND_VERTEX, x, y, z, 4'($urandom), $urandom, last);
	endtask

	task automatic load_entry(logic [3:0] idx, logic [31:0] val);
		send_item(KIND_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), idx, val,
			1'($urandom_range(0, 1)));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		s_axis_tvalid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		checker_h.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (checker_h.expected_results.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 1200)) - 600);
		endcase
	endfunction

	function automatic logic [31:0] pick_entry_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h0;
			default: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
		endcase
	endfunction

	task automatic write_all_regs();
		for (int i = 0; i < 6; i++) write_reg(CFG_IDX_W'(i), pick_reg_value());
	endtask

	task automatic random_batches(int count);
		int n;
		n = 0;
		while (n < count) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1)) load_entry(4'($urandom), $urandom);
				else send_vertex(16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
				n++;
			end else begin
				int loads, verts;
				loads = $urandom_range(1, 4);
				verts = $urandom_range(3, 12);
				for (int i = 0; i < loads; i++) load_entry(4'($urandom), pick_entry_value());
				for (int i = 0; i < verts; i++) begin
					if ($urandom_range(0, 5) == 0)
						send_vertex(16'($urandom), 16'($urandom), 16'($urandom),
							i == verts - 1);
					else
						send_vertex(16'($signed($urandom_range(0, 400)) - 200),
							16'($signed($urandom_range(0, 400)) - 200),
							16'($signed($urandom_range(0, 400)) - 200), i == verts - 1);
				end
				n += loads + verts;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		checker_h = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_VERTEX;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		no_stalls = 1'b0;
		hold_off = 1'b0;
		cycle_count = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// vertex through the all-zero reset matrix
		send_vertex(16'd5, 16'd6, 16'd7, 1'b0);
		wait_drained();
		write_reg(CFG_VIEW_SCALE_X, 16'd160);
		write_reg(CFG_VIEW_SCALE_Y, 16'hFF60);
		write_reg(CFG_VIEW_TRANS_X, 16'd160);
		write_reg(CFG_VIEW_TRANS_Y, 16'd120);
		write_reg(CFG_FOG_SCALE, 16'd200);
		write_reg(CFG_FOG_BIAS, 16'd10);

		// identity with w of one, coordinate extremes
		load_entry(4'd0, 32'h0001_0000);
		load_entry(4'd5, 32'h0001_0000);
		load_entry(4'd10, 32'h0001_0000);
		load_entry(4'd15, 32'h0001_0000);
		send_vertex(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
		send_vertex(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
		send_vertex(16'h0000, 16'h0000, 16'h8000, 1'b1);
		// w of zero: positive, negative and zero numerators
		load_entry(4'd15, 32'h0);
		send_vertex(16'd3, 16'hFFFD, 16'd0, 1'b0);
		send_vertex(16'd0, 16'd0, 16'd0, 1'b1);
		// negative w forces fog to zero
		load_entry(4'd15, 32'hFFFF_0000);
		send_vertex(16'd1, 16'd2, 16'd3, 1'b0);
		// near plane boundary just below and just above 0.1
		load_entry(4'd15, 32'd6553);
		send_vertex(16'd1, 16'd1, 16'd1, 1'b0);
		load_entry(4'd15, 32'd6554);
		send_vertex(16'd1, 16'd1, 16'd1, 1'b1);
		// extreme matrix entries
		load_entry(4'd3, 32'h7FFF_FFFF);
		load_entry(4'd12, 32'h8000_0000);
		send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			write_all_regs();
			no_stalls = (phase == 3);
			if (phase == 1) hold_off = 1'b1;
			random_batches(250);
			wait_drained();
		end

		$display("covered %0d vertices and %0d matrix loads, %0d results checked",
			checker_h.n_vertices, checker_h.n_loads, checker_h.n_results);
		if (checker_h.errors == 0 && checker_h.expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
